/* src/hue_pkg.sv */
`default_nettype none
package hue_pkg;

  // Number of protect character slots held in the protect register.
  localparam int PROTECT_SLOTS = 8;
  localparam int SlotCntW = $clog2(PROTECT_SLOTS + 1);

  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 64;
  localparam logic [CfgIdxW-1:0] REG_ENCODE_MODE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_PROTECT_CHARS = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_PROTECT_COUNT = 2'd2;

  localparam logic MODE_HTML = 1'b0;
  localparam logic MODE_URL = 1'b1;

  localparam logic [3:0] MAX_BACKSLASHES = 4'd15;

  localparam logic [7:0] CH_AMP = 8'h26;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_APOS = 8'h27;
  localparam logic [7:0] CH_LT = 8'h3C;
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_PCT = 8'h25;
  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  typedef enum logic [1:0] {
    KIND_RAW,
    KIND_PCT,
    KIND_ENT
  } kind_e;

  typedef enum logic [2:0] {
    ENT_AMP,
    ENT_QUOT,
    ENT_APOS,
    ENT_LT,
    ENT_GT
  } ent_e;

  // Decoded form of one input word: what the emitter walks through.
  typedef struct packed {
    logic [7:0] chr;
    logic [3:0] bs;
    kind_e      kind;
    ent_e       ent;
    logic [4:0] len;
  } desc_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'd0, v};
    end else begin
      r = 8'h41 + {4'd0, v} - 8'd10;
    end
    return r;
  endfunction

  function automatic logic [2:0] ent_len(input ent_e e);
    logic [2:0] r;
    case (e)
      ENT_AMP: r = 3'd5;
      ENT_QUOT: r = 3'd6;
      ENT_APOS: r = 3'd6;
      ENT_LT: r = 3'd4;
      ENT_GT: r = 3'd4;
      default: r = 3'd4;
    endcase
    return r;
  endfunction

  // Byte t of the entity text, starting at the leading ampersand.
  function automatic logic [7:0] ent_byte(input ent_e e, input logic [2:0] t);
    logic [7:0] r;
    r = CH_SEMI;
    if (t == 3'd0) begin
      r = CH_AMP;
    end else begin
      case (e)
        ENT_AMP: begin
          case (t)
            3'd1: r = 8'h61;  // a
            3'd2: r = 8'h6D;  // m
            3'd3: r = 8'h70;  // p
            default: r = CH_SEMI;
          endcase
        end
        ENT_QUOT: begin
          case (t)
            3'd1: r = 8'h71;  // q
            3'd2: r = 8'h75;  // u
            3'd3: r = 8'h6F;  // o
            3'd4: r = 8'h74;  // t
            default: r = CH_SEMI;
          endcase
        end
        ENT_APOS: begin
          case (t)
            3'd1: r = CH_HASH;
            3'd2: r = 8'h30;
            3'd3: r = 8'h33;
            3'd4: r = 8'h39;
            default: r = CH_SEMI;
          endcase
        end
        ENT_LT: begin
          case (t)
            3'd1: r = 8'h6C;  // l
            3'd2: r = 8'h74;  // t
            default: r = CH_SEMI;
          endcase
        end
        ENT_GT: begin
          case (t)
            3'd1: r = 8'h67;  // g
            3'd2: r = 8'h74;  // t
            default: r = CH_SEMI;
          endcase
        end
        default: r = CH_SEMI;
      endcase
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/hue_decode.sv */
`default_nettype none
module hue_decode (
  input  wire logic                          encode_mode_i,
  input  wire logic [hue_pkg::CfgDataW-1:0]  protect_chars_i,
  input  wire logic [3:0]                    protect_count_i,
  input  wire logic [7:0]                    char_in_i,
  output hue_pkg::desc_t                     desc_o
);

  logic [3:0]                  slots;
  logic [hue_pkg::SlotCntW-1:0] k;
  logic [4:0]                  bs_wide;
  logic [3:0]                  bs;

  always_comb begin
    if (protect_count_i > 4'(hue_pkg::PROTECT_SLOTS)) begin
      slots = 4'(hue_pkg::PROTECT_SLOTS);
    end else begin
      slots = protect_count_i;
    end
    k = '0;
    for (int i = 0; i < hue_pkg::PROTECT_SLOTS; i++) begin
      if ((4'(i) < slots) && (protect_chars_i[8*i +: 8] == char_in_i)) begin
        k = k + 1'b1;
      end
    end
    if (k == '0) begin
      bs_wide = 5'd0;
    end else begin
      bs_wide = 5'({k, 1'b0}) - 5'd1;
    end
    if (bs_wide > 5'({1'b0, hue_pkg::MAX_BACKSLASHES})) begin
      bs = hue_pkg::MAX_BACKSLASHES;
    end else begin
      bs = bs_wide[3:0];
    end
  end

  always_comb begin
    desc_o.chr = char_in_i;
    desc_o.bs = 4'd0;
    desc_o.kind = hue_pkg::KIND_RAW;
    desc_o.ent = hue_pkg::ENT_AMP;
    desc_o.len = 5'd1;
    if (encode_mode_i == hue_pkg::MODE_HTML) begin
      desc_o.kind = hue_pkg::KIND_ENT;
      case (char_in_i)
        hue_pkg::CH_AMP: desc_o.ent = hue_pkg::ENT_AMP;
        hue_pkg::CH_QUOT: desc_o.ent = hue_pkg::ENT_QUOT;
        hue_pkg::CH_APOS: desc_o.ent = hue_pkg::ENT_APOS;
        hue_pkg::CH_LT: desc_o.ent = hue_pkg::ENT_LT;
        hue_pkg::CH_GT: desc_o.ent = hue_pkg::ENT_GT;
        default: desc_o.kind = hue_pkg::KIND_RAW;
      endcase
      if (desc_o.kind == hue_pkg::KIND_ENT) begin
        desc_o.len = {2'd0, hue_pkg::ent_len(desc_o.ent)};
      end
    end else begin
      desc_o.bs = bs;
      case (char_in_i)
        hue_pkg::CH_AMP, hue_pkg::CH_QUOT, hue_pkg::CH_APOS, hue_pkg::CH_LT,
        hue_pkg::CH_GT, hue_pkg::CH_PLUS, hue_pkg::CH_HASH: begin
          desc_o.kind = hue_pkg::KIND_PCT;
          desc_o.len = {1'b0, bs} + 5'd3;
        end
        default: begin
          desc_o.len = {1'b0, bs} + 5'd1;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* src/hue_emit.sv */
`default_nettype none
module hue_emit (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           desc_valid_i,
  input  wire hue_pkg::desc_t desc_i,
  output logic                desc_done_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic                last_of_run_o
);

  logic [4:0] pos_q, pos_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic       load;
  logic       is_last;
  logic [4:0] tail_pos;

  assign load = desc_valid_i && (!out_valid_q || !out_stall_i);
  assign is_last = (pos_q == desc_i.len - 5'd1);
  assign tail_pos = pos_q - {1'b0, desc_i.bs};
  assign desc_done_o = load && is_last;

  always_comb begin
    out_byte_d = desc_i.chr;
    if (pos_q < {1'b0, desc_i.bs}) begin
      out_byte_d = hue_pkg::CH_BSL;
    end else begin
      case (desc_i.kind)
        hue_pkg::KIND_PCT: begin
          case (tail_pos[1:0])
            2'd0: out_byte_d = hue_pkg::CH_PCT;
            2'd1: out_byte_d = hue_pkg::hex_digit(desc_i.chr[7:4]);
            default: out_byte_d = hue_pkg::hex_digit(desc_i.chr[3:0]);
          endcase
        end
        hue_pkg::KIND_ENT: out_byte_d = hue_pkg::ent_byte(desc_i.ent, tail_pos[2:0]);
        default: out_byte_d = desc_i.chr;
      endcase
    end
  end

  always_comb begin
    pos_d = pos_q;
    out_valid_d = out_valid_q;
    out_last_d = out_last_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_last_d = is_last;
      pos_d = is_last ? 5'd0 : pos_q + 5'd1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 5'd0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= out_byte_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o = out_byte_q;
  assign last_of_run_o = out_last_q;

endmodule
`default_nettype wire

/* src/html_url_char_escaper.sv */
// HTML / URL character escaper.
// Input channel: in_valid_i / in_stall_o carry one text byte (char_in_i) per word.
// Output channel: out_valid_o / out_stall_i carry the escaped run one byte per
// word; last_of_run_o marks the final byte of the run for each input byte.
// A run is 1 to 18 bytes long: one byte for plain characters, 4 to 6 for HTML
// entities, and in URL mode up to 15 backslashes followed by 1 or 3 bytes.
// The input word is registered in the decode register and its first output byte
// then in the output byte register. While the receiver does not stall, one
// output byte goes out per cycle and an input byte is taken every cycle while
// runs are one byte long; a run of N bytes holds the input stalled until its
// last byte is loaded into the single output byte register.
// The byte being expanded sits in a decode register; the next input word is
// taken in the same cycle its last output byte is loaded.
// When the receiver stalls, the output word holds and the input stalls once
// the decode register is full. Configuration (cfg_we_i, cfg_idx_i, cfg_data_i)
// is written by the user while the block is idle, which it does not enforce;
// index 0 selects the mode, 1 the protect characters, 2 their count. Reset clears
// all pipeline valids and sets the registers to HTML mode, no protect characters.
`default_nettype none
module html_url_char_escaper (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [hue_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [hue_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    char_in_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [7:0]                         out_byte_o,
  output logic                               last_of_run_o
);

  logic                         encode_mode_q;
  logic [hue_pkg::CfgDataW-1:0] protect_chars_q;
  logic [3:0]                   protect_count_q;

  hue_pkg::desc_t desc_d, desc_q;
  logic           desc_valid_q;
  logic           desc_done;
  logic           in_accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      encode_mode_q <= hue_pkg::MODE_HTML;
      protect_chars_q <= '0;
      protect_count_q <= 4'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hue_pkg::REG_ENCODE_MODE: encode_mode_q <= cfg_data_i[0];
        hue_pkg::REG_PROTECT_CHARS: protect_chars_q <= cfg_data_i;
        hue_pkg::REG_PROTECT_COUNT: protect_count_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  hue_decode u_decode (
    .encode_mode_i  (encode_mode_q),
    .protect_chars_i(protect_chars_q),
    .protect_count_i(protect_count_q),
    .char_in_i      (char_in_i),
    .desc_o         (desc_d)
  );

  assign in_stall_o = desc_valid_q && !desc_done;
  assign in_accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_valid_q <= 1'b0;
    end else if (in_accept) begin
      desc_valid_q <= 1'b1;
    end else if (desc_done) begin
      desc_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      desc_q <= desc_d;
    end
  end

  hue_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (desc_valid_q),
    .desc_i       (desc_q),
    .desc_done_o  (desc_done),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule
`default_nettype wire

/* src/hue_checker.sv */
`default_nettype none
module hue_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       last_of_run_o
);

  // No output word once reset has been applied at an edge.
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(last_of_run_o))
    else $error("stalled output word changed");

  // Inside a run the next byte follows without a gap.
  a_run_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_run_o |=> out_valid_o)
    else $error("gap inside an escape run");

  // A percent sign that is not the end of a run starts a hex pair.
  a_pct_hex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_run_o && out_byte_o == 8'h25
      |=> !last_of_run_o && ((out_byte_o >= 8'h30 && out_byte_o <= 8'h39)
      || (out_byte_o >= 8'h41 && out_byte_o <= 8'h46)))
    else $error("percent sign not followed by a hex digit");

  // A held-off input with a free receiver means a byte goes out next cycle.
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o && !out_stall_i |=> out_valid_o)
    else $error("input stalled with no output progress");

endmodule

bind html_url_char_escaper hue_checker u_hue_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_byte_o   (out_byte_o),
  .last_of_run_o(last_of_run_o)
);
`default_nettype wire

/* tb/escape_checker.sv */
`timescale 1ns / 100ps
module escape_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [hue_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hue_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [7:0]                   char_in_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [7:0]                   out_byte_i,
  input  logic                         last_of_run_i,
  output int                           mismatch_cnt_o,
  output int                           words_due_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } esc_word_t;

  esc_word_t   esc_bytes_q[$];
  logic        mode_q;
  logic [63:0] protect_q;
  logic [3:0]  prot_cnt_q;

  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    return (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h37 + 8'(nib);
  endfunction

  function automatic bit needs_pct(input logic [7:0] c);
    return c inside {hue_pkg::CH_AMP, hue_pkg::CH_QUOT, hue_pkg::CH_APOS, hue_pkg::CH_LT,
                     hue_pkg::CH_GT, hue_pkg::CH_PLUS, hue_pkg::CH_HASH};
  endfunction

  // Expands one input byte into its escaped run and queues it.
  task automatic predict_escape(input logic [7:0] c);
    logic [7:0] run[$];
    string      ent;
    int         hits;
    int         slots;
    int         nbs;
    ent = "";
    hits = 0;
    if (mode_q == hue_pkg::MODE_HTML) begin
      case (c)
        hue_pkg::CH_AMP:  ent = "&amp;";
        hue_pkg::CH_QUOT: ent = "&quot;";
        hue_pkg::CH_APOS: ent = "&#039;";
        hue_pkg::CH_LT:   ent = "&lt;";
        hue_pkg::CH_GT:   ent = "&gt;";
        default: ent = "";
      endcase
      if (ent.len() == 0) begin
        run.push_back(c);
      end
      for (int i = 0; i < ent.len(); i++) begin
        run.push_back(ent[i]);
      end
    end else begin
      // count register can exceed the slot count; extra slots don't exist
      slots = (prot_cnt_q > hue_pkg::PROTECT_SLOTS) ? hue_pkg::PROTECT_SLOTS
                                                     : int'(prot_cnt_q);
      for (int i = 0; i < slots; i++) begin
        if (protect_q[8*i +: 8] == c) begin
          hits++;
        end
      end
      nbs = (hits == 0) ? 0 : 2 * hits - 1;
      if (nbs > int'(hue_pkg::MAX_BACKSLASHES)) begin
        nbs = int'(hue_pkg::MAX_BACKSLASHES);
      end
      repeat (nbs) run.push_back(hue_pkg::CH_BSL);
      if (needs_pct(c)) begin
        run.push_back(hue_pkg::CH_PCT);
        run.push_back(hex_ascii(c[7:4]));
        run.push_back(hex_ascii(c[3:0]));
      end else begin
        run.push_back(c);
      end
    end
    for (int i = 0; i < run.size(); i++) begin
      esc_bytes_q.push_back('{data: run[i], last: (i == run.size() - 1)});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    esc_word_t want;
    if (!rst_ni) begin
      mode_q = hue_pkg::MODE_HTML;
      protect_q = '0;
      prot_cnt_q = '0;
      esc_bytes_q.delete();
      mismatch_cnt_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (esc_bytes_q.size() == 0) begin
          $display("%0t: unexpected word, byte %h last %b", $time, out_byte_i,
                   last_of_run_i);
          mismatch_cnt_o++;
        end else begin
          want = esc_bytes_q.pop_front();
          if (out_byte_i !== want.data) begin
            $display("%0t: out_byte expected %h, actual %h", $time, want.data, out_byte_i);
            mismatch_cnt_o++;
          end
          if (last_of_run_i !== want.last) begin
            $display("%0t: last_of_run expected %b, actual %b", $time, want.last,
                     last_of_run_i);
            mismatch_cnt_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_escape(char_in_i);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          hue_pkg::REG_ENCODE_MODE:   mode_q = cfg_data_i[0];
          hue_pkg::REG_PROTECT_CHARS: protect_q = cfg_data_i;
          hue_pkg::REG_PROTECT_COUNT: prot_cnt_q = cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
    words_due_o = esc_bytes_q.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
module testbench;

  localparam int RESET_CYCLES = 7;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_AT = 60;
  localparam int HOLD_CYCLES = 150;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 25;

  localparam logic [7:0] SPECIALS[7] = '{
    hue_pkg::CH_AMP, hue_pkg::CH_QUOT, hue_pkg::CH_APOS, hue_pkg::CH_LT,
    hue_pkg::CH_GT, hue_pkg::CH_PLUS, hue_pkg::CH_HASH};
  localparam logic [7:0] HTML_CASES[12] = '{
    hue_pkg::CH_AMP, hue_pkg::CH_QUOT, hue_pkg::CH_APOS, hue_pkg::CH_LT,
    hue_pkg::CH_GT, hue_pkg::CH_PLUS, hue_pkg::CH_HASH, 8'h61, 8'h01, 8'h7F,
    8'h80, 8'hFF};
  localparam logic [7:0] URL_CASES[8] = '{
    hue_pkg::CH_AMP, hue_pkg::CH_HASH, 8'h78, 8'h61, hue_pkg::CH_PLUS,
    8'hFF, 8'h01, 8'h7A};

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [hue_pkg::CfgIdxW-1:0]  cfg_idx = '0;
  logic [hue_pkg::CfgDataW-1:0] cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic [7:0]                   char_in = 8'h20;
  logic                         out_stall = 1'b0;
  logic                         in_stall;
  logic                         out_valid;
  logic [7:0]                   out_byte;
  logic                         last_of_run;

  int          mismatch_cnt;
  int          words_due;
  int          sent_cnt = 0;
  int          cycle_cnt = 0;
  bit          hold_done = 1'b0;
  bit          steady = 1'b0;
  logic [63:0] stim_protect = '0;
  int          stim_count = 0;

  always #6 clk_i = ~clk_i;

  html_url_char_escaper u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .char_in_i    (char_in),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_byte_o   (out_byte),
    .last_of_run_o(last_of_run)
  );

  escape_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .char_in_i     (char_in),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_byte_i    (out_byte),
    .last_of_run_i (last_of_run),
    .mismatch_cnt_o(mismatch_cnt),
    .words_due_o   (words_due)
  );

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Output side: random stall segments, plus one long hold once traffic is flowing.
  initial begin : receiver
    int seg;
    int len;
    forever begin
      @(negedge clk_i);
      if (!hold_done && sent_cnt >= HOLD_AT) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      seg = $urandom_range(0, 9);
      if (seg < 5) begin
        out_stall <= 1'b0;
        len = $urandom_range(1, 20);
      end else if (seg < 9) begin
        out_stall <= 1'b1;
        len = $urandom_range(1, 3);
      end else begin
        out_stall <= 1'b1;
        len = $urandom_range(10, 40);
      end
      repeat (len - 1) @(negedge clk_i);
    end
  end

  task automatic send_char(input logic [7:0] c);
    int pick;
    int gap;
    in_valid <= 1'b1;
    char_in <= c;
    do @(posedge clk_i); while (in_stall);
    sent_cnt++;
    @(negedge clk_i);
    pick = $urandom_range(0, 9);
    if (steady || pick < 6) begin
      gap = 0;
    end else if (pick < 9) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 30);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (words_due != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [hue_pkg::CfgIdxW-1:0] idx,
                           input logic [hue_pkg::CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic mode, input logic [63:0] chars, input logic [3:0] cnt);
    write_cfg(hue_pkg::REG_ENCODE_MODE, {63'd0, mode});
    write_cfg(hue_pkg::REG_PROTECT_CHARS, chars);
    write_cfg(hue_pkg::REG_PROTECT_COUNT, {60'd0, cnt});
    stim_protect = chars;
    stim_count = int'(cnt);
  endtask

  // Slots mix random bytes, escapable chars and repeats of slot 0 so that
  // multi-match backslash runs show up.
  function automatic logic [63:0] pick_protect();
    logic [63:0] v;
    int          r;
    v = '0;
    for (int i = 0; i < hue_pkg::PROTECT_SLOTS; i++) begin
      r = $urandom_range(0, 2);
      if (r == 0 || i == 0) begin
        v[8*i +: 8] = 8'($urandom_range(0, 255));
      end else if (r == 1) begin
        v[8*i +: 8] = SPECIALS[$urandom_range(0, 6)];
      end else begin
        v[8*i +: 8] = v[7:0];
      end
    end
    return v;
  endfunction

  function automatic logic [7:0] pick_char();
    int         sel;
    int         slot;
    int         slots;
    logic [7:0] c;
    sel = $urandom_range(0, 9);
    slots = (stim_count > hue_pkg::PROTECT_SLOTS) ? hue_pkg::PROTECT_SLOTS : stim_count;
    c = 8'($urandom_range(1, 255));
    if (sel < 4) begin
      c = SPECIALS[$urandom_range(0, 6)];
    end else if (sel < 7 && slots > 0) begin
      slot = $urandom_range(0, slots - 1);
      if (stim_protect[8*slot +: 8] != 8'h00) begin
        c = stim_protect[8*slot +: 8];
      end
    end
    return c;
  endfunction

  initial begin : stimulus
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // HTML mode straight out of reset
    foreach (HTML_CASES[i]) send_char(HTML_CASES[i]);
    wait_idle();

    // every slot matches '&': full backslash run plus percent code
    set_config(hue_pkg::MODE_URL, {8{hue_pkg::CH_AMP}}, 4'd8);
    for (int i = 0; i < 3; i++) send_char(URL_CASES[i]);
    wait_idle();

    // count above slot number, a zero slot, single and repeated matches
    set_config(hue_pkg::MODE_URL,
               {8'h61, 8'h01, 8'hFF, 8'h61, 8'h00, hue_pkg::CH_PLUS, 8'h61, 8'h61},
               4'd15);
    for (int i = 3; i < 8; i++) send_char(URL_CASES[i]);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: set_config(hue_pkg::MODE_URL, '1, 4'd8);
        1: set_config(hue_pkg::MODE_URL, '0, 4'd8);
        2: set_config(hue_pkg::MODE_HTML, pick_protect(), 4'd0);
        default: set_config(1'($urandom_range(0, 1)), pick_protect(),
                            4'($urandom_range(0, 8)));
      endcase
      steady = (ph % 3 == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) send_char(pick_char());
    end

    wait_idle();
    repeat (20) @(negedge clk_i);
    if (mismatch_cnt == 0 && words_due == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
